// ===== design/cna_pkg.sv =====
// ----------------------------------------------------------------------------
// cna_pkg: shared definitions for the complex arithmetic unit
// This package holds the operation codes that the top-level pipeline and the
// bench decode.
// ----------------------------------------------------------------------------
package cna_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

endpackage

// ===== design/cna_prod.sv =====
// ----------------------------------------------------------------------------
// cna_prod: first pipeline stage, six signed products
// This module forms the four cross products and the two squares of b, and
// registers them together with the operands.
// ----------------------------------------------------------------------------
module cna_prod #(
	parameter int WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [WIDTH-1:0]   a_re,
	input  logic signed [WIDTH-1:0]   a_im,
	input  logic signed [WIDTH-1:0]   b_re,
	input  logic signed [WIDTH-1:0]   b_im,
	output logic signed [WIDTH-1:0]   a_re_s1,
	output logic signed [WIDTH-1:0]   a_im_s1,
	output logic signed [WIDTH-1:0]   b_re_s1,
	output logic signed [WIDTH-1:0]   b_im_s1,
	output logic signed [2*WIDTH-1:0] p_rr_s1,
	output logic signed [2*WIDTH-1:0] p_ii_s1,
	output logic signed [2*WIDTH-1:0] p_ri_s1,
	output logic signed [2*WIDTH-1:0] p_ir_s1,
	output logic [2*WIDTH-1:0]        sq_re_s1,
	output logic [2*WIDTH-1:0]        sq_im_s1
);

	logic signed [2*WIDTH-1:0] sq_re;
	logic signed [2*WIDTH-1:0] sq_im;

	// Squares are never negative, so their bit patterns read as unsigned.
	assign sq_re = b_re * b_re;
	assign sq_im = b_im * b_im;

	always_ff @(posedge clk) begin
		if (en) begin
			a_re_s1  <= a_re;
			a_im_s1  <= a_im;
			b_re_s1  <= b_re;
			b_im_s1  <= b_im;
			p_rr_s1  <= a_re * b_re;
			p_ii_s1  <= a_im * b_im;
			p_ri_s1  <= a_re * b_im;
			p_ir_s1  <= a_im * b_re;
			sq_re_s1 <= unsigned'(sq_re);
			sq_im_s1 <= unsigned'(sq_im);
		end
	end

endmodule

// ===== design/cna_div.sv =====
// ----------------------------------------------------------------------------
// cna_div: pipelined restoring divider lane
// This module divides an unsigned numerator by an unsigned divisor, one
// quotient bit per stage, and flags quotients of 2^WIDTH or more.
// ----------------------------------------------------------------------------
module cna_div #(
	parameter int WIDTH = 16,
	parameter int FRAC  = 8
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [2*WIDTH+FRAC-1:0]   num,
	input  logic [2*WIDTH-1:0]        den,
	output logic [WIDTH-1:0]          quo,
	output logic                      big
);

	localparam int NW = 2 * WIDTH + FRAC;
	localparam int DW = 2 * WIDTH;
	localparam int CW = 3 * WIDTH + FRAC;

	logic [NW-1:0]    rem_q [0:WIDTH];
	logic [DW-1:0]    den_q [0:WIDTH];
	logic [WIDTH-1:0] quo_q [0:WIDTH];
	logic             big_q [0:WIDTH];

	// The first stage decides whether the quotient fits in WIDTH bits at all.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num;
			den_q[0] <= den;
			quo_q[0] <= '0;
			big_q[0] <= CW'(num) >= (CW'(den) << WIDTH);
		end
	end

	for (genvar k = 1; k <= WIDTH; k++) begin : g_stage
		localparam int BIT = WIDTH - k;
		logic [CW-1:0] shd;
		logic          fits;

		assign shd  = CW'(den_q[k-1]) << BIT;
		assign fits = CW'(rem_q[k-1]) >= shd;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= fits ? NW'(CW'(rem_q[k-1]) - shd) : rem_q[k-1];
				den_q[k] <= den_q[k-1];
				big_q[k] <= big_q[k-1];
				quo_q[k] <= quo_q[k-1] | (WIDTH'(fits) << BIT);
			end
		end
	end

	assign quo = quo_q[WIDTH];
	assign big = big_q[WIDTH];

endmodule

// ===== design/complex_number_alu.sv =====
// ----------------------------------------------------------------------------
// complex_number_alu: pipelined complex add, subtract, multiply and divide
// Signed fixed-point operands with FRAC fraction bits; every part of the
// result is saturated to WIDTH bits and flagged on overflow.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Beat contents
//  --------+----------------------+------------------------------------------
//  req     | req_valid, req_stall | op, a_re, a_im, b_re, b_im
//  rsp     | rsp_valid, rsp_stall | res_re, res_im, overflow, div_zero
//
// One beat can enter in every cycle unless a held result stalls the pipeline;
// a result is offered once its beat has passed the product stage, the sum
// stage, the divider stages, which settle one quotient bit per stage, and the
// output register. Every operation takes the same path, so beats leave in order.
// Reset clears only the valid bits of the stages.
// A held result stalls the whole pipeline, and req_stall follows it at once.
//
module complex_number_alu #(
	parameter int WIDTH = 16,
	parameter int FRAC  = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [1:0]              op,
	input  logic signed [WIDTH-1:0] a_re,
	input  logic signed [WIDTH-1:0] a_im,
	input  logic signed [WIDTH-1:0] b_re,
	input  logic signed [WIDTH-1:0] b_im,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic signed [WIDTH-1:0] res_re,
	output logic signed [WIDTH-1:0] res_im,
	output logic                    overflow,
	output logic                    div_zero
);

	localparam int PW = 2 * WIDTH;
	localparam int SW = 2 * WIDTH + 1;
	localparam int NW = 2 * WIDTH + FRAC;
	localparam int DEPTH = WIDTH;

	logic adv;

	// The pipeline moves as one whenever the output register is free or is
	// being emptied in this cycle.
	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	// ---- Stage 1: products ----
	logic                    v_s1;
	cna_pkg::op_t            op_s1;
	logic signed [WIDTH-1:0] a_re_s1, a_im_s1, b_re_s1, b_im_s1;
	logic signed [PW-1:0]    p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic [PW-1:0]           sq_re_s1, sq_im_s1;

	cna_prod #(.WIDTH(WIDTH)) u_prod (
		.clk      (clk),
		.en       (adv),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.a_re_s1  (a_re_s1),
		.a_im_s1  (a_im_s1),
		.b_re_s1  (b_re_s1),
		.b_im_s1  (b_im_s1),
		.p_rr_s1  (p_rr_s1),
		.p_ii_s1  (p_ii_s1),
		.p_ri_s1  (p_ri_s1),
		.p_ir_s1  (p_ir_s1),
		.sq_re_s1 (sq_re_s1),
		.sq_im_s1 (sq_im_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= cna_pkg::op_t'(op);
		end
	end

	// ---- Stage 2: sums, the divisor and numerator magnitudes ----
	// Add, subtract and multiply finish here apart from saturation; their
	// value then rides alongside the divider stages.
	logic signed [SW-1:0] m_re, m_im, d_re, d_im;
	logic signed [SW-1:0] alt_re, alt_im;
	logic [PW-1:0]        mag_re, mag_im;

	assign m_re = SW'(p_rr_s1) - SW'(p_ii_s1);
	assign m_im = SW'(p_ri_s1) + SW'(p_ir_s1);
	assign d_re = SW'(p_rr_s1) + SW'(p_ii_s1);
	assign d_im = SW'(p_ir_s1) - SW'(p_ri_s1);

	// A dot product never exceeds 2^(2*WIDTH-1) in magnitude, so PW bits hold it.
	assign mag_re = d_re[SW-1] ? PW'(-d_re) : PW'(d_re);
	assign mag_im = d_im[SW-1] ? PW'(-d_im) : PW'(d_im);

	always_comb begin
		case (op_s1)
			cna_pkg::OP_ADD: begin
				alt_re = SW'(a_re_s1) + SW'(b_re_s1);
				alt_im = SW'(a_im_s1) + SW'(b_im_s1);
			end
			cna_pkg::OP_SUB: begin
				alt_re = SW'(a_re_s1) - SW'(b_re_s1);
				alt_im = SW'(a_im_s1) - SW'(b_im_s1);
			end
			cna_pkg::OP_MUL: begin
				alt_re = m_re >>> FRAC;
				alt_im = m_im >>> FRAC;
			end
			default: begin
				alt_re = '0;
				alt_im = '0;
			end
		endcase
	end

	logic                 v_s2;
	cna_pkg::op_t         op_s2;
	logic signed [SW-1:0] alt_re_s2, alt_im_s2;
	logic [NW-1:0]        num_re_s2, num_im_s2;
	logic                 neg_re_s2, neg_im_s2;
	logic [PW-1:0]        den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2     <= op_s1;
			alt_re_s2 <= alt_re;
			alt_im_s2 <= alt_im;
			num_re_s2 <= NW'(mag_re) << FRAC;
			num_im_s2 <= NW'(mag_im) << FRAC;
			neg_re_s2 <= d_re[SW-1];
			neg_im_s2 <= d_im[SW-1];
			den_s2    <= sq_re_s1 + sq_im_s1;
		end
	end

	// ---- Divider stages, with the rest of the beat carried alongside ----
	logic [WIDTH-1:0] quo_re, quo_im;
	logic             big_re, big_im;

	cna_div #(.WIDTH(WIDTH), .FRAC(FRAC)) u_div_re (
		.clk (clk),
		.en  (adv),
		.num (num_re_s2),
		.den (den_s2),
		.quo (quo_re),
		.big (big_re)
	);

	cna_div #(.WIDTH(WIDTH), .FRAC(FRAC)) u_div_im (
		.clk (clk),
		.en  (adv),
		.num (num_im_s2),
		.den (den_s2),
		.quo (quo_im),
		.big (big_im)
	);

	logic                 v_d_q      [0:DEPTH];
	cna_pkg::op_t         op_d_q     [0:DEPTH];
	logic signed [SW-1:0] alt_re_d_q [0:DEPTH];
	logic signed [SW-1:0] alt_im_d_q [0:DEPTH];
	logic                 neg_re_d_q [0:DEPTH];
	logic                 neg_im_d_q [0:DEPTH];
	logic                 dz_d_q     [0:DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DEPTH; i++) begin
				v_d_q[i] <= 1'b0;
			end
		end else if (adv) begin
			v_d_q[0] <= v_s2;
			for (int i = 1; i <= DEPTH; i++) begin
				v_d_q[i] <= v_d_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_d_q[0]     <= op_s2;
			alt_re_d_q[0] <= alt_re_s2;
			alt_im_d_q[0] <= alt_im_s2;
			neg_re_d_q[0] <= neg_re_s2;
			neg_im_d_q[0] <= neg_im_s2;
			dz_d_q[0]     <= (op_s2 == cna_pkg::OP_DIV) && (den_s2 == '0);
			for (int i = 1; i <= DEPTH; i++) begin
				op_d_q[i]     <= op_d_q[i-1];
				alt_re_d_q[i] <= alt_re_d_q[i-1];
				alt_im_d_q[i] <= alt_im_d_q[i-1];
				neg_re_d_q[i] <= neg_re_d_q[i-1];
				neg_im_d_q[i] <= neg_im_d_q[i-1];
				dz_d_q[i]     <= dz_d_q[i-1];
			end
		end
	end

	// ---- Final stage: sign, saturation and selection ----
	localparam logic [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};

	logic [WIDTH-1:0] sat_re, sat_im, dq_re, dq_im;
	logic             sov_re, sov_im, dov_re, dov_im;
	logic [WIDTH-1:0] fin_re, fin_im;
	logic             fin_ovf;

	// A wide sum fits when all bits above the result's sign agree with it.
	always_comb begin
		sov_re = (alt_re_d_q[DEPTH][SW-1:WIDTH-1] != '0) &&
			(alt_re_d_q[DEPTH][SW-1:WIDTH-1] != '1);
		sov_im = (alt_im_d_q[DEPTH][SW-1:WIDTH-1] != '0) &&
			(alt_im_d_q[DEPTH][SW-1:WIDTH-1] != '1);
		sat_re = sov_re ? (alt_re_d_q[DEPTH][SW-1] ? MINV : MAXV)
			: alt_re_d_q[DEPTH][WIDTH-1:0];
		sat_im = sov_im ? (alt_im_d_q[DEPTH][SW-1] ? MINV : MAXV)
			: alt_im_d_q[DEPTH][WIDTH-1:0];
	end

	// A negative quotient may reach one step further than a positive one.
	always_comb begin
		if (neg_re_d_q[DEPTH]) begin
			dov_re = big_re || (quo_re[WIDTH-1] && (quo_re[WIDTH-2:0] != '0));
			dq_re  = dov_re ? MINV : WIDTH'(-quo_re);
		end else begin
			dov_re = big_re || quo_re[WIDTH-1];
			dq_re  = dov_re ? MAXV : quo_re;
		end
		if (neg_im_d_q[DEPTH]) begin
			dov_im = big_im || (quo_im[WIDTH-1] && (quo_im[WIDTH-2:0] != '0));
			dq_im  = dov_im ? MINV : WIDTH'(-quo_im);
		end else begin
			dov_im = big_im || quo_im[WIDTH-1];
			dq_im  = dov_im ? MAXV : quo_im;
		end
	end

	always_comb begin
		if (dz_d_q[DEPTH]) begin
			fin_re  = '0;
			fin_im  = '0;
			fin_ovf = 1'b0;
		end else if (op_d_q[DEPTH] == cna_pkg::OP_DIV) begin
			fin_re  = dq_re;
			fin_im  = dq_im;
			fin_ovf = dov_re || dov_im;
		end else begin
			fin_re  = sat_re;
			fin_im  = sat_im;
			fin_ovf = sov_re || sov_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= v_d_q[DEPTH];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_re   <= signed'(fin_re);
			res_im   <= signed'(fin_im);
			overflow <= fin_ovf;
			div_zero <= dz_d_q[DEPTH];
		end
	end

endmodule

// ===== design/cna_checker.sv =====
// ----------------------------------------------------------------------------
// cna_checker: port-level checks for the complex arithmetic unit
// This module watches the handshake and the result flags over time.
// ----------------------------------------------------------------------------
module cna_checker #(
	parameter int WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_stall,
	input logic                    rsp_valid,
	input logic                    rsp_stall,
	input logic signed [WIDTH-1:0] res_re,
	input logic signed [WIDTH-1:0] res_im,
	input logic                    overflow,
	input logic                    div_zero
);

	localparam logic [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};

	// A result that is held back stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// Requests are only held off by a stalled result.
	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without back-pressure");

	// A zero divisor gives a clean zero result.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && div_zero |-> res_re == '0 && res_im == '0 && !overflow)
		else $error("divide-by-zero result not zero");

	// Overflow always leaves at least one part at a bound.
	a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow |->
			unsigned'(res_re) == MAXV || unsigned'(res_re) == MINV ||
			unsigned'(res_im) == MAXV || unsigned'(res_im) == MINV)
		else $error("overflow flagged without a saturated part");

endmodule

bind complex_number_alu cna_checker #(.WIDTH(WIDTH)) u_cna_checker (.*);

// ===== bench/complex_number_alu_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_number_alu_tb: self-checking bench for the complex arithmetic unit
// Directed corner beats and random beats of all four operations are driven
// through the request channel with random gaps. Every result beat is checked
// field by field against a fixed-point prediction computed in the bench.
// ----------------------------------------------------------------------------
module complex_number_alu_tb;

	localparam int WIDTH     = 16;
	localparam int FRAC      = 8;
	localparam int N_RANDOM  = 1850;
	localparam int MAX_CYCLES = 400000;

	// One request beat and one result beat as the bench sees them.
	typedef struct {
		cna_pkg::op_t            op;
		logic signed [WIDTH-1:0] a_re, a_im, b_re, b_im;
	} req_beat_t;

	typedef struct {
		logic signed [WIDTH-1:0] re, im;
		logic                    ovf, dz;
	} res_beat_t;

	logic                    clk;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_stall;
	logic [1:0]              op;
	logic signed [WIDTH-1:0] a_re, a_im, b_re, b_im;
	logic                    rsp_valid;
	logic                    rsp_stall;
	logic signed [WIDTH-1:0] res_re, res_im;
	logic                    overflow, div_zero;

	req_beat_t pending_beats[$];
	res_beat_t expected_results[$];
	int        errors;
	int        cycle_count;
	bit        stimulus_done;
	// Set while the sender is to hold back until the pipeline has drained.
	bit        drain_request;
	// Set while the receiver holds off for a long stretch.
	bit        long_hold;
	int        hold_cycles;

	complex_number_alu #(.WIDTH(WIDTH), .FRAC(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.op(op), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.res_re(res_re), .res_im(res_im),
		.overflow(overflow), .div_zero(div_zero)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Clamp a wide exact value to WIDTH bits, raising the overflow flag if
	// the clamp was needed.
	function automatic logic signed [WIDTH-1:0] clamp_part(
		input logic signed [79:0] v, inout logic ovf);
		logic signed [79:0] hi_lim;
		logic signed [79:0] lo_lim;
		hi_lim = (80'sd1 <<< (WIDTH - 1)) - 80'sd1;
		lo_lim = -(80'sd1 <<< (WIDTH - 1));
		if (v > hi_lim) begin
			ovf = 1'b1;
			return hi_lim[WIDTH-1:0];
		end else if (v < lo_lim) begin
			ovf = 1'b1;
			return lo_lim[WIDTH-1:0];
		end
		return v[WIDTH-1:0];
	endfunction

	// The complex result that one request beat must produce.
	function automatic res_beat_t complex_result(input req_beat_t b);
		res_beat_t r;
		logic signed [79:0] ar, ai, br, bi, pre, pim, den, mre, mim, qre, qim;
		ar = b.a_re; ai = b.a_im; br = b.b_re; bi = b.b_im;
		r.ovf = 1'b0; r.dz = 1'b0; r.re = '0; r.im = '0;
		case (b.op)
			cna_pkg::OP_ADD: begin
				r.re = clamp_part(ar + br, r.ovf);
				r.im = clamp_part(ai + bi, r.ovf);
			end
			cna_pkg::OP_SUB: begin
				r.re = clamp_part(ar - br, r.ovf);
				r.im = clamp_part(ai - bi, r.ovf);
			end
			cna_pkg::OP_MUL: begin
				// Arithmetic shift rounds toward minus infinity.
				pre = (ar * br - ai * bi) >>> FRAC;
				pim = (ar * bi + ai * br) >>> FRAC;
				r.re = clamp_part(pre, r.ovf);
				r.im = clamp_part(pim, r.ovf);
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					// Signed division in SystemVerilog truncates toward zero.
					mre = (ar * br + ai * bi) <<< FRAC;
					mim = (ai * br - ar * bi) <<< FRAC;
					qre = mre / den;
					qim = mim / den;
					r.re = clamp_part(qre, r.ovf);
					r.im = clamp_part(qim, r.ovf);
				end
			end
		endcase
		return r;
	endfunction

	// Operand values biased towards the edges of the range.
	function automatic logic signed [WIDTH-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sd0;
			3: return $signed(16'($urandom_range(0, 7))) - 16'sd3;
			4: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
			default: return $signed(16'($urandom));
		endcase
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 3)
			return $urandom_range(20, 60);
		if ($urandom_range(0, 99) < 50)
			return 0;
		return $urandom_range(1, 3);
	endfunction

	task automatic queue_beat(input cna_pkg::op_t o,
		input logic signed [WIDTH-1:0] ar, ai, br, bi);
		req_beat_t b;
		b.op = o; b.a_re = ar; b.a_im = ai; b.b_re = br; b.b_im = bi;
		pending_beats.push_back(b);
	endtask

	// Stimulus: directed corners first, then random beats with both pressure
	// phases somewhere in the middle.
	initial begin
		cna_pkg::op_t o;
		errors = 0;
		stimulus_done = 1'b0;
		drain_request = 1'b0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < 4; k++) begin
			o = cna_pkg::op_t'(k);
			queue_beat(o, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
			queue_beat(o, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
			queue_beat(o, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
			queue_beat(o, 16'sd256, -16'sd256, 16'sd512, 16'sd128);
		end
		// Zero divisor, with non-zero and with zero dividends.
		queue_beat(cna_pkg::OP_DIV, 16'sh1234, -16'sh0F00, 16'sd0, 16'sd0);
		queue_beat(cna_pkg::OP_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		// Tiny divisor makes the quotient saturate.
		queue_beat(cna_pkg::OP_DIV, 16'sh7FFF, 16'sh8000, 16'sd1, 16'sd0);
		// Negative products show the rounding towards minus infinity.
		queue_beat(cna_pkg::OP_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0);
		queue_beat(cna_pkg::OP_DIV, -16'sd1, 16'sd1, 16'sd3, -16'sd7);
		queue_beat(cna_pkg::OP_SUB, 16'sh8000, 16'sh7FFF, 16'sd1, -16'sd1);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				// Sender pauses until the pipeline is empty.
				wait (pending_beats.size() == 0);
				drain_request = 1'b1;
				wait (expected_results.size() == 0);
				@(posedge clk);
				drain_request = 1'b0;
			end
			if (n == (2 * N_RANDOM) / 3) begin
				long_hold = 1'b1;
			end
			o = cna_pkg::op_t'($urandom_range(0, 3));
			if (o == cna_pkg::OP_DIV && $urandom_range(0, 19) == 0)
				queue_beat(o, pick_operand(), pick_operand(), 16'sd0, 16'sd0);
			else
				queue_beat(o, pick_operand(), pick_operand(), pick_operand(), pick_operand());
			if (pending_beats.size() > 64)
				wait (pending_beats.size() < 16);
		end
		wait (pending_beats.size() == 0);
		stimulus_done = 1'b1;
	end

	// Driver: the payload stays put while the block stalls it.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			op <= '0; a_re <= '0; a_im <= '0; b_re <= '0; b_im <= '0;
			send_gap = 0;
		end else begin
			if (req_valid && !req_stall)
				expected_results.push_back(complex_result(pending_beats.pop_front()));
			if (req_valid && req_stall) begin
				// Held beat: nothing changes.
			end else if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (pending_beats.size() > 0 && !drain_request) begin
				req_valid <= 1'b1;
				op <= pending_beats[0].op;
				a_re <= pending_beats[0].a_re;
				a_im <= pending_beats[0].a_im;
				b_re <= pending_beats[0].b_re;
				b_im <= pending_beats[0].b_im;
				send_gap = pick_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each accepted result beat and chooses the next stall.
	res_beat_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no request outstanding");
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (res_re !== want.re) begin
						$error("res_re expected %0d actual %0d", want.re, res_re);
						errors++;
					end
					if (res_im !== want.im) begin
						$error("res_im expected %0d actual %0d", want.im, res_im);
						errors++;
					end
					if (overflow !== want.ovf) begin
						$error("overflow expected %0b actual %0b", want.ovf, overflow);
						errors++;
					end
					if (div_zero !== want.dz) begin
						$error("div_zero expected %0b actual %0b", want.dz, div_zero);
						errors++;
					end
				end
			end
			if (long_hold) begin
				// Long hold-off so that the pipeline fills and stalls its input.
				hold_cycles++;
				rsp_stall <= 1'b1;
				if (hold_cycles >= 200)
					long_hold <= 1'b0;
			end else if (hold_cycles > 0 && hold_cycles < 1000) begin
				hold_cycles = 1000;
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= (pick_gap() > 0);
			end
		end
	end

	// Run control: drain, a latency margin, then the verdict, or a timeout.
	initial begin
		cycle_count = 0;
		fork
			begin
				wait (stimulus_done && expected_results.size() == 0);
				repeat (3 * (WIDTH + 4)) @(posedge clk);
			end
			begin
				while (cycle_count < MAX_CYCLES) begin
					@(posedge clk);
					cycle_count++;
				end
				$display("RESULT: ERROR");
				$finish;
			end
		join_any
		if (errors == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
